>>> sv/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel unit.
package hsvrgb_pkg;

   // Fixed field widths of the pixel ports.
   localparam int HUE_IN_WIDTH  = 16;
   localparam int UNIT_IN_WIDTH = 12;
   localparam int CHAN_WIDTH    = 8;

   // Largest channel code.
   localparam logic [CHAN_WIDTH-1:0] CHAN_MAX = 8'hFF;

   // 60-degree sector of the hue circle, named by its start and end color.
   typedef enum logic [2:0] {
      SECTOR_RED_YEL = 3'd0,
      SECTOR_YEL_GRN = 3'd1,
      SECTOR_GRN_CYN = 3'd2,
      SECTOR_CYN_BLU = 3'd3,
      SECTOR_BLU_MAG = 3'd4,
      SECTOR_MAG_RED = 3'd5
   } sector_type;

endpackage

>>> sv/hsvrgb_prep.sv
// First pipeline stage: clamp saturation and value, split hue into sector and weight.
module hsvrgb_prep #(
   parameter int HUE_BITS       = 16,
   parameter int UNIT_FRAC_BITS = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [hsvrgb_pkg::HUE_IN_WIDTH-1:0]           hue_turn,
   input  logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0]   saturation,
   input  logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0]   brightness,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [UNIT_FRAC_BITS:0]                       out_sat,
   output logic [UNIT_FRAC_BITS:0]                       out_val,
   output logic [HUE_BITS:0]                             out_weight,
   output hsvrgb_pkg::sector_type                        out_sector
);

   localparam int VW = UNIT_FRAC_BITS + 1;
   localparam int HW = (HUE_BITS < hsvrgb_pkg::HUE_IN_WIDTH) ?
                       HUE_BITS : hsvrgb_pkg::HUE_IN_WIDTH;
   localparam logic [31:0]       ONE_WIDE = 32'd1 << UNIT_FRAC_BITS;
   localparam logic [VW-1:0]     ONE      = VW'(1) << UNIT_FRAC_BITS;
   localparam logic [HUE_BITS:0] TURN     = (HUE_BITS+1)'(1) << HUE_BITS;

   function automatic logic [VW-1:0] clamp_unit(
      input logic [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] raw
   );
      logic [VW-1:0] res;
      if (raw[hsvrgb_pkg::UNIT_IN_WIDTH-1]) begin
         res = '0;
      end else if (32'(raw) > ONE_WIDE) begin
         res = ONE;
      end else begin
         res = VW'(raw);
      end
      return res;
   endfunction

   logic [HUE_BITS-1:0]    hue;
   logic [HUE_BITS+2:0]    scaled;
   logic [HUE_BITS:0]      weight_in;
   hsvrgb_pkg::sector_type sector_in;
   logic                   valid_ff;
   logic                   advance;
   logic [VW-1:0]          sat_ff;
   logic [VW-1:0]          val_ff;
   logic [HUE_BITS:0]      weight_ff;
   hsvrgb_pkg::sector_type sector_ff;

   // Hue wraps modulo a full turn; six times it gives sector and position.
   assign hue    = HUE_BITS'(hue_turn[HW-1:0]);
   assign scaled = (HUE_BITS+3)'({hue, 2'b00}) + (HUE_BITS+3)'({hue, 1'b0});
   assign sector_in = hsvrgb_pkg::sector_type'(scaled[HUE_BITS+2:HUE_BITS]);

   // Weight of the secondary channel: T - |pos - T|.
   always_comb begin
      if (scaled[HUE_BITS]) begin
         weight_in = TURN - {1'b0, scaled[HUE_BITS-1:0]};
      end else begin
         weight_in = {1'b0, scaled[HUE_BITS-1:0]};
      end
   end

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         sat_ff    <= clamp_unit(saturation);
         val_ff    <= clamp_unit(brightness);
         weight_ff <= weight_in;
         sector_ff <= sector_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sat    = sat_ff;
   assign out_val    = val_ff;
   assign out_weight = weight_ff;
   assign out_sector = sector_ff;

endmodule

>>> sv/hsvrgb_chroma.sv
// Chroma stages: c = v*s, then secondary term c*weight and offset m = v - c.
module hsvrgb_chroma #(
   parameter int HUE_BITS       = 16,
   parameter int UNIT_FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [UNIT_FRAC_BITS:0]                in_sat,
   input  logic [UNIT_FRAC_BITS:0]                in_val,
   input  logic [HUE_BITS:0]                      in_weight,
   input  hsvrgb_pkg::sector_type                 in_sector,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [2*UNIT_FRAC_BITS:0]              out_chroma,
   output logic [2*UNIT_FRAC_BITS:0]              out_offset,
   output logic [2*UNIT_FRAC_BITS+HUE_BITS:0]     out_second,
   output hsvrgb_pkg::sector_type                 out_sector
);

   localparam int VW = UNIT_FRAC_BITS + 1;
   localparam int CW = 2 * UNIT_FRAC_BITS + 1;
   localparam int NW = 2 * UNIT_FRAC_BITS + HUE_BITS + 1;

   logic [2*VW-1:0]          chroma_prod;
   logic [CW+HUE_BITS:0]     second_prod;
   logic [CW-1:0]            val_scaled;

   logic                     mul_valid_ff;
   logic                     mul_advance;
   logic [CW-1:0]            mul_chroma_ff;
   logic [VW-1:0]            mul_val_ff;
   logic [HUE_BITS:0]        mul_weight_ff;
   hsvrgb_pkg::sector_type   mul_sector_ff;

   logic                     sec_valid_ff;
   logic                     sec_advance;
   logic [CW-1:0]            sec_chroma_ff;
   logic [CW-1:0]            sec_offset_ff;
   logic [NW-1:0]            sec_second_ff;
   hsvrgb_pkg::sector_type   sec_sector_ff;

   // Chroma product; at most U*U, so it fits CW bits.
   assign chroma_prod = in_sat * in_val;

   assign sec_advance = !sec_valid_ff || out_ready;
   assign mul_advance = !mul_valid_ff || sec_advance;
   assign in_ready    = mul_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         if (mul_advance) begin
            mul_valid_ff <= in_valid;
         end
         if (sec_advance) begin
            sec_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_advance && in_valid) begin
         mul_chroma_ff <= chroma_prod[CW-1:0];
         mul_val_ff    <= in_val;
         mul_weight_ff <= in_weight;
         mul_sector_ff <= in_sector;
      end
   end

   // Secondary term c*(T-d) stays within U*U*T.
   assign second_prod = mul_chroma_ff * mul_weight_ff;
   assign val_scaled  = {mul_val_ff, {UNIT_FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (sec_advance && mul_valid_ff) begin
         sec_chroma_ff <= mul_chroma_ff;
         sec_offset_ff <= val_scaled - mul_chroma_ff;
         sec_second_ff <= second_prod[NW-1:0];
         sec_sector_ff <= mul_sector_ff;
      end
   end

   assign out_valid  = sec_valid_ff;
   assign out_chroma = sec_chroma_ff;
   assign out_offset = sec_offset_ff;
   assign out_second = sec_second_ff;
   assign out_sector = sec_sector_ff;

endmodule

>>> sv/hsvrgb_mix.sv
// Mix stages: route terms to channels by sector, then scale each to a byte.
module hsvrgb_mix #(
   parameter int HUE_BITS       = 16,
   parameter int UNIT_FRAC_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [2*UNIT_FRAC_BITS:0]                in_chroma,
   input  logic [2*UNIT_FRAC_BITS:0]                in_offset,
   input  logic [2*UNIT_FRAC_BITS+HUE_BITS:0]       in_second,
   input  hsvrgb_pkg::sector_type                   in_sector,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [hsvrgb_pkg::CHAN_WIDTH-1:0]        out_red,
   output logic [hsvrgb_pkg::CHAN_WIDTH-1:0]        out_green,
   output logic [hsvrgb_pkg::CHAN_WIDTH-1:0]        out_blue
);

   localparam int CHW = hsvrgb_pkg::CHAN_WIDTH;
   localparam int SH  = 2 * UNIT_FRAC_BITS + HUE_BITS;
   localparam int NW  = SH + 1;
   localparam int PW  = NW + CHW;

   function automatic logic [CHW-1:0] to_byte(input logic [NW-1:0] sum);
      logic [PW-1:0] prod;
      logic [CHW:0]  quot;
      logic [CHW-1:0] res;
      // sum*255 as a shift and subtract, then drop the full-scale bits
      prod = {sum, {CHW{1'b0}}} - PW'(sum);
      quot = prod[SH+CHW:SH];
      if (quot[CHW]) begin
         res = hsvrgb_pkg::CHAN_MAX;
      end else begin
         res = quot[CHW-1:0];
      end
      return res;
   endfunction

   logic [NW-1:0] primary;
   logic [NW-1:0] offset;
   logic [NW-1:0] red_sel;
   logic [NW-1:0] green_sel;
   logic [NW-1:0] blue_sel;

   logic          sum_valid_ff;
   logic          sum_advance;
   logic [NW-1:0] red_sum_ff;
   logic [NW-1:0] green_sum_ff;
   logic [NW-1:0] blue_sum_ff;

   logic           out_valid_ff;
   logic           out_advance;
   logic [CHW-1:0] red_ff;
   logic [CHW-1:0] green_ff;
   logic [CHW-1:0] blue_ff;

   assign primary = {in_chroma, {HUE_BITS{1'b0}}};
   assign offset  = {in_offset, {HUE_BITS{1'b0}}};

   always_comb begin
      red_sel   = '0;
      green_sel = '0;
      blue_sel  = '0;
      case (in_sector)
         hsvrgb_pkg::SECTOR_RED_YEL: begin
            red_sel   = primary;
            green_sel = in_second;
         end
         hsvrgb_pkg::SECTOR_YEL_GRN: begin
            red_sel   = in_second;
            green_sel = primary;
         end
         hsvrgb_pkg::SECTOR_GRN_CYN: begin
            green_sel = primary;
            blue_sel  = in_second;
         end
         hsvrgb_pkg::SECTOR_CYN_BLU: begin
            green_sel = in_second;
            blue_sel  = primary;
         end
         hsvrgb_pkg::SECTOR_BLU_MAG: begin
            red_sel  = in_second;
            blue_sel = primary;
         end
         default: begin
            red_sel  = primary;
            blue_sel = in_second;
         end
      endcase
   end

   assign out_advance = !out_valid_ff || out_ready;
   assign sum_advance = !sum_valid_ff || out_advance;
   assign in_ready    = sum_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (sum_advance) begin
            sum_valid_ff <= in_valid;
         end
         if (out_advance) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
   end

   // Channel plus offset never exceeds full scale, so NW bits hold the sum.
   always_ff @(posedge clock) begin
      if (sum_advance && in_valid) begin
         red_sum_ff   <= red_sel + offset;
         green_sum_ff <= green_sel + offset;
         blue_sum_ff  <= blue_sel + offset;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && sum_valid_ff) begin
         red_ff   <= to_byte(red_sum_ff);
         green_ff <= to_byte(green_sum_ff);
         blue_ff  <= to_byte(blue_sum_ff);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

>>> sv/hsv_to_rgb_pixel_unit.sv
// Top level of the HSV to RGB pixel unit: five-stage conversion pipeline.
//
//   channel   ports   beat contents                          direction
//   -------   -----   ------------------------------------   ---------
//   request   req_    hue_turn, saturation, brightness       in
//   response  rsp_    red, green, blue                       out
//
// While rsp_ready holds, one beat enters per clock, set by the two-multiplier
// chroma path split over its own stages. Each stage holds a valid bit and
// advances when empty or when the next stage advances, so bubbles collapse and
// a stalled response holds only the full stages behind it. Reset (synchronous,
// active high) clears the valid bits; data registers are not reset. No state
// is kept between pixels.
module hsv_to_rgb_pixel_unit #(
   parameter int HUE_BITS       = 16,
   parameter int UNIT_FRAC_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [hsvrgb_pkg::HUE_IN_WIDTH-1:0]         req_hue_turn,
   input  logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] req_saturation,
   input  logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] req_brightness,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [hsvrgb_pkg::CHAN_WIDTH-1:0]           rsp_red,
   output logic [hsvrgb_pkg::CHAN_WIDTH-1:0]           rsp_green,
   output logic [hsvrgb_pkg::CHAN_WIDTH-1:0]           rsp_blue
);

   localparam int VW = UNIT_FRAC_BITS + 1;
   localparam int CW = 2 * UNIT_FRAC_BITS + 1;
   localparam int NW = 2 * UNIT_FRAC_BITS + HUE_BITS + 1;

   // Prep to chroma.
   logic                   prep_valid;
   logic                   prep_ready;
   logic [VW-1:0]          prep_sat;
   logic [VW-1:0]          prep_val;
   logic [HUE_BITS:0]      prep_weight;
   hsvrgb_pkg::sector_type prep_sector;

   // Chroma to mix.
   logic                   chroma_valid;
   logic                   chroma_ready;
   logic [CW-1:0]          chroma_c;
   logic [CW-1:0]          chroma_m;
   logic [NW-1:0]          chroma_x;
   hsvrgb_pkg::sector_type chroma_sector;

   // Stage 1: clamp inputs, locate the hue sector and the secondary weight.
   hsvrgb_prep #(
      .HUE_BITS       (HUE_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .hue_turn   (req_hue_turn),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_sat    (prep_sat),
      .out_val    (prep_val),
      .out_weight (prep_weight),
      .out_sector (prep_sector)
   );

   // Stages 2 and 3: chroma product, then secondary term and offset.
   hsvrgb_chroma #(
      .HUE_BITS       (HUE_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_chroma (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prep_valid),
      .in_ready   (prep_ready),
      .in_sat     (prep_sat),
      .in_val     (prep_val),
      .in_weight  (prep_weight),
      .in_sector  (prep_sector),
      .out_valid  (chroma_valid),
      .out_ready  (chroma_ready),
      .out_chroma (chroma_c),
      .out_offset (chroma_m),
      .out_second (chroma_x),
      .out_sector (chroma_sector)
   );

   // Stages 4 and 5: route terms per channel, scale to bytes, hold the beat.
   hsvrgb_mix #(
      .HUE_BITS       (HUE_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chroma_valid),
      .in_ready  (chroma_ready),
      .in_chroma (chroma_c),
      .in_offset (chroma_m),
      .in_second (chroma_x),
      .in_sector (chroma_sector),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   // Reset drains the pipeline: no response beat right after it.
   a_reset_drains: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Backpressure only starts at the response port: the request side may stall
   // only when every stage is full and the response beat is being held.
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a held response");

   // A taken response with a full pipeline never blocks the request side.
   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

endmodule

>>> verif/hsv_to_rgb_pixel_unit_tb.sv
// Self-checking testbench for the HSV to RGB pixel unit: directed and random pixels.
module hsv_to_rgb_pixel_unit_tb;

   localparam int HUE_BITS       = 16;
   localparam int UNIT_FRAC_BITS = 8;
   localparam logic [63:0] HUE_TURN  = 64'd1 << HUE_BITS;
   localparam logic [63:0] UNIT_ONE  = 64'd1 << UNIT_FRAC_BITS;
   localparam int DEN_SHIFT = 2 * UNIT_FRAC_BITS + HUE_BITS;
   localparam int RANDOM_PIXELS = 1900;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic [hsvrgb_pkg::HUE_IN_WIDTH-1:0]         hue;
      logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] sat;
      logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] bri;
   } hsv_pixel_type;

   typedef struct packed {
      logic [hsvrgb_pkg::CHAN_WIDTH-1:0] red;
      logic [hsvrgb_pkg::CHAN_WIDTH-1:0] green;
      logic [hsvrgb_pkg::CHAN_WIDTH-1:0] blue;
   } rgb_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [hsvrgb_pkg::HUE_IN_WIDTH-1:0] req_hue_turn = '0;
   logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] req_saturation = '0;
   logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] req_brightness = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [hsvrgb_pkg::CHAN_WIDTH-1:0] rsp_red;
   logic [hsvrgb_pkg::CHAN_WIDTH-1:0] rsp_green;
   logic [hsvrgb_pkg::CHAN_WIDTH-1:0] rsp_blue;

   // Pixels waiting to be driven, and colors predicted for pixels already taken.
   hsv_pixel_type pixel_backlog[$];
   rgb_pixel_type predicted_rgb[$];

   // Handshake flags sampled at the rising edge, consumed at the falling edge.
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   int mismatch_count = 0;
   int pixels_sent = 0;
   int colors_seen = 0;
   int req_gap = 0;
   int rsp_stall = 0;

   hsv_to_rgb_pixel_unit #(
      .HUE_BITS      (HUE_BITS),
      .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_hue_turn  (req_hue_turn),
      .req_saturation(req_saturation),
      .req_brightness(req_brightness),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp a signed unit value to 0..1.0; negative codes become zero.
   function automatic logic [63:0] clamp_unit(
      logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] raw
   );
      logic [63:0] mag;
      if (raw < 0) return 64'd0;
      mag = 64'(raw);
      return (mag > UNIT_ONE) ? UNIT_ONE : mag;
   endfunction

   // Scale a channel numerator to 0..255, truncating and saturating at the top.
   function automatic logic [hsvrgb_pkg::CHAN_WIDTH-1:0] scale_chan(logic [63:0] num);
      logic [63:0] q;
      q = (num * 64'd255) >> DEN_SHIFT;
      return (q > 64'd255) ? hsvrgb_pkg::CHAN_MAX : q[hsvrgb_pkg::CHAN_WIDTH-1:0];
   endfunction

   // Exact fixed-point HSV to RGB: chroma, six-sector split, then add the floor m.
   function automatic rgb_pixel_type convert_hsv(hsv_pixel_type px);
      logic [63:0] h, s, v, chroma, floor_m, p, pos, hue_dist;
      logic [63:0] cs, xs, ms, r, g, b;
      hsvrgb_pkg::sector_type sector;
      rgb_pixel_type res;
      h = 64'(px.hue) & (HUE_TURN - 64'd1);
      s = clamp_unit(px.sat);
      v = clamp_unit(px.bri);
      chroma  = v * s;
      floor_m = v * UNIT_ONE - chroma;
      p    = h * 64'd6;
      pos  = p & ((HUE_TURN << 1) - 64'd1);
      hue_dist = (pos >= HUE_TURN) ? pos - HUE_TURN : HUE_TURN - pos;
      cs = chroma << HUE_BITS;
      xs = chroma * (HUE_TURN - hue_dist);
      ms = floor_m << HUE_BITS;
      r = 64'd0;
      g = 64'd0;
      b = 64'd0;
      sector = hsvrgb_pkg::sector_type'(3'(p >> HUE_BITS));
      case (sector)
         hsvrgb_pkg::SECTOR_RED_YEL: begin r = cs; g = xs; end
         hsvrgb_pkg::SECTOR_YEL_GRN: begin r = xs; g = cs; end
         hsvrgb_pkg::SECTOR_GRN_CYN: begin g = cs; b = xs; end
         hsvrgb_pkg::SECTOR_CYN_BLU: begin g = xs; b = cs; end
         hsvrgb_pkg::SECTOR_BLU_MAG: begin r = xs; b = cs; end
         default: begin r = cs; b = xs; end
      endcase
      res.red   = scale_chan(r + ms);
      res.green = scale_chan(g + ms);
      res.blue  = scale_chan(b + ms);
      return res;
   endfunction

   task automatic check_chan(string name, logic [hsvrgb_pkg::CHAN_WIDTH-1:0] want,
                             logic [hsvrgb_pkg::CHAN_WIDTH-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   function automatic logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] random_unit();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return hsvrgb_pkg::UNIT_IN_WIDTH'($urandom_range(0, 256));
      if (pick < 7) return hsvrgb_pkg::UNIT_IN_WIDTH'($urandom_range(250, 262));
      return hsvrgb_pkg::UNIT_IN_WIDTH'($urandom);
   endfunction

   // Rising edge: note the handshakes, predict each taken pixel, check each color beat.
   always @(posedge clock) begin
      rgb_pixel_type want;
      rgb_pixel_type got;
      req_took <= !reset && req_valid && req_ready;
      rsp_took <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            predicted_rgb.push_back(convert_hsv({req_hue_turn, req_saturation,
                                                 req_brightness}));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red, rsp_green, rsp_blue};
            if (predicted_rgb.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected color beat, expected none, actual %h",
                        $time, got);
            end else begin
               want = predicted_rgb.pop_front();
               check_chan("red", want.red, got.red);
               check_chan("green", want.green, got.green);
               check_chan("blue", want.blue, got.blue);
            end
         end
      end
   end

   // Request driver: present the next pixel after a random gap, hold until taken.
   // Every third stretch of 100 pixels runs back to back with no gaps.
   always @(negedge clock) begin
      hsv_pixel_type nxt;
      if (!reset) begin
         if (req_took) begin
            pixels_sent++;
            req_gap = ((pixels_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 6);
         end
         if (!req_valid || req_took) begin
            if (req_gap > 0 || pixel_backlog.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_valid <= 1'b0;
            end else begin
               nxt = pixel_backlog.pop_front();
               req_hue_turn   <= nxt.hue;
               req_saturation <= nxt.sat;
               req_brightness <= nxt.bri;
               req_valid      <= 1'b1;
            end
         end
      end
   end

   // Response side: drop ready for a random stall after each color beat, except every third 100.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            colors_seen++;
            rsp_stall = ((colors_seen / 100) % 3 == 2) ? 0 : $urandom_range(0, 6);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [hsvrgb_pkg::HUE_IN_WIDTH-1:0] hue_edges[$];
      logic signed [hsvrgb_pkg::UNIT_IN_WIDTH-1:0] unit_edges[$];
      hsv_pixel_type px;
      int k;

      // Hues on and around each 60-degree boundary, plus both ends of the turn.
      hue_edges = {16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
                   16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'hFFFF};
      // Negative, zero, around one, and the code extremes.
      unit_edges = {-12'sd2048, -12'sd1, 12'sd0, 12'sd1, 12'sd255, 12'sd256,
                    12'sd257, 12'sd2047};

      // Full saturation and value around the hue circle.
      foreach (hue_edges[i])
         pixel_backlog.push_back(hsv_pixel_type'{hue_edges[i], 12'sd256, 12'sd256});
      // Saturation and value sweeps through the clamp edges.
      foreach (unit_edges[i]) begin
         pixel_backlog.push_back(hsv_pixel_type'{16'd5000, unit_edges[i], 12'sd200});
         pixel_backlog.push_back(hsv_pixel_type'{16'd40000, 12'sd128, unit_edges[i]});
      end

      for (k = 0; k < RANDOM_PIXELS; k++) begin
         px.hue = (k % 8 == 0) ? hue_edges[$urandom_range(0, hue_edges.size() - 1)]
                               : hsvrgb_pkg::HUE_IN_WIDTH'($urandom);
         px.sat = random_unit();
         px.bri = random_unit();
         pixel_backlog.push_back(px);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pixel_backlog.size() == 0 && !req_valid);
      wait (predicted_rgb.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("hsv_to_rgb_pixel_unit_tb: done, clean");
      else
         $display("hsv_to_rgb_pixel_unit_tb: done, errors");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #400000;
      $display("hsv_to_rgb_pixel_unit_tb: done, errors");
      $finish;
   end

endmodule

>>> sim.f
sv/hsvrgb_pkg.sv
sv/hsvrgb_prep.sv
sv/hsvrgb_chroma.sv
sv/hsvrgb_mix.sv
sv/hsv_to_rgb_pixel_unit.sv
verif/hsv_to_rgb_pixel_unit_tb.sv
